[design/lru_block_buffer_cache_macros.svh]
// ----------------------------------------------------------------------------
// LRU block buffer cache assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LRU_BLOCK_BUFFER_CACHE_MACROS_SVH
`define LRU_BLOCK_BUFFER_CACHE_MACROS_SVH

`ifndef SYNTH
`define LBC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("lbc assertion failed");
`define LBC_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("lbc forbidden condition");
`else
`define LBC_ASSERT(lbl, clk, rstn, prop)
`define LBC_NEVER(lbl, clk, rstn, cond)
`endif

`endif

[design/lbc_pkg.sv]
// ----------------------------------------------------------------------------
// LRU block buffer cache package
// Shared widths, codes, state encoding and control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package lbc_pkg;

  localparam int unsigned NumSlotsDflt = 32;
  localparam int unsigned DevW         = 8;
  localparam int unsigned BlkW         = 32;
  localparam int unsigned CntW         = 8;
  localparam int unsigned SlotW        = 5;
  localparam int unsigned InDataW      = 48;
  localparam int unsigned OutDataW     = 16;
  localparam logic [CntW-1:0] CntMax   = 8'd255;

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_FREE  = 2'd1,
    STAT_ZERO     = 2'd2,
    STAT_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_R_ISSUE,
    S_R_EVAL,
    S_A_SCAN,
    S_A_DECIDE,
    S_M_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic clear;
    logic en;
  } srch_ctrl_t;

endpackage

`default_nettype wire

[design/lbc_ram.sv]
// ----------------------------------------------------------------------------
// LBC generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[design/lbc_search.sv]
// ----------------------------------------------------------------------------
// LBC search unit
// Walks slot entries one per cycle while enabled: most recent tag match, least recent free.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_search #(
  parameter int unsigned IDX_W = 5
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire lbc_pkg::srch_ctrl_t      ctrl_i,
  input  wire logic [IDX_W-1:0]         idx_i,
  input  wire logic                     asg_i,
  input  wire logic [lbc_pkg::DevW-1:0] dev_i,
  input  wire logic [lbc_pkg::BlkW-1:0] blk_i,
  input  wire logic [lbc_pkg::CntW-1:0] cnt_i,
  input  wire logic [IDX_W-1:0]         rank_i,
  input  wire logic [lbc_pkg::DevW-1:0] req_dev_i,
  input  wire logic [lbc_pkg::BlkW-1:0] req_blk_i,
  output logic                          hit_o,
  output logic      [IDX_W-1:0]         hit_idx_o,
  output logic      [lbc_pkg::CntW-1:0] hit_cnt_o,
  output logic      [IDX_W-1:0]         hit_rank_o,
  output logic                          free_o,
  output logic      [IDX_W-1:0]         free_idx_o,
  output logic      [IDX_W-1:0]         free_rank_o
);

  import lbc_pkg::*;

  logic             hit_q, free_q;
  logic [IDX_W-1:0] hit_idx_q, hit_rank_q, free_idx_q, free_rank_q;
  logic [CntW-1:0]  hit_cnt_q;
  logic             match, take_hit, take_free;

  assign match     = asg_i && (dev_i == req_dev_i) && (blk_i == req_blk_i);
  assign take_hit  = ctrl_i.en && match && (!hit_q || (rank_i < hit_rank_q));
  assign take_free = ctrl_i.en && (cnt_i == '0) && (!free_q || (rank_i > free_rank_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else begin
      if (take_hit) begin
        hit_q <= 1'b1;
      end
      if (take_free) begin
        free_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_hit) begin
      hit_idx_q  <= idx_i;
      hit_cnt_q  <= cnt_i;
      hit_rank_q <= rank_i;
    end
    if (take_free) begin
      free_idx_q  <= idx_i;
      free_rank_q <= rank_i;
    end
  end

  assign hit_o       = hit_q;
  assign hit_idx_o   = hit_idx_q;
  assign hit_cnt_o   = hit_cnt_q;
  assign hit_rank_o  = hit_rank_q;
  assign free_o      = free_q;
  assign free_idx_o  = free_idx_q;
  assign free_rank_o = free_rank_q;

endmodule

`default_nettype wire

[design/lru_block_buffer_cache.sv]
// ----------------------------------------------------------------------------
// LRU block buffer cache
// Acquire: from input transfer to result valid, one scan walk then a decide step.
// Release to zero: read, evaluate, rank update walk; others: read, evaluate.
// Both walks read the slot RAM one entry per cycle; one request at a time,
// the next input transfer is taken the cycle after the result register loads.
// Reset clears per-slot written flags at once; unwritten slots read as reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_block_buffer_cache_macros.svh"

module lru_block_buffer_cache #(
  parameter int unsigned NUM_SLOTS = lbc_pkg::NumSlotsDflt
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // device[7:0], block_number[39:8], slot_index[44:40]
  input  wire logic [lbc_pkg::InDataW-1:0]  s_axis_tdata,
  // operation[1:0]
  input  wire logic [1:0]                   s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // result_slot[4:0], hit[5], needs_fill[6], references[14:7]
  output logic      [lbc_pkg::OutDataW-1:0] m_axis_tdata,
  // status[1:0]
  output logic      [1:0]                   m_axis_tuser
);

  import lbc_pkg::*;

  localparam int unsigned IdxW = $clog2(NUM_SLOTS);
  localparam int unsigned EntW = 1 + DevW + BlkW + CntW + IdxW;
  localparam logic [IdxW:0]   SlotsCnt = (IdxW+1)'(NUM_SLOTS);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(NUM_SLOTS - 1);

  state_e            state_q, state_d;
  op_e               op_q;
  logic [DevW-1:0]   dev_q;
  logic [BlkW-1:0]   blk_q;
  logic [SlotW-1:0]  idx_q;
  logic [IdxW:0]     rd_cnt_q, rd_cnt_d;
  logic              rd_vld_q;
  logic [IdxW-1:0]   rd_idx_q;
  logic [IdxW-1:0]   mru_rank_q, mru_rank_d;
  logic [SlotW-1:0]  res_slot_q, res_slot_d;
  logic              res_hit_q, res_hit_d, res_fill_q, res_fill_d;
  status_e           res_status_q, res_status_d;
  logic [CntW-1:0]   res_refs_q, res_refs_d;
  logic              out_vld_q;
  logic [OutDataW-1:0] out_data_q;
  logic [1:0]        out_user_q;
  logic [NUM_SLOTS-1:0] written_q;

  logic              in_xfer, load_out;
  logic [DevW-1:0]   s_dev;
  logic [BlkW-1:0]   s_blk;
  logic [SlotW-1:0]  s_idx;
  logic [IdxW-1:0]   idx_addr;
  logic              ram_we, ram_re;
  logic [IdxW-1:0]   ram_waddr, ram_raddr;
  logic [EntW-1:0]   ram_wdata, ram_rdata, ent;
  logic              e_asg;
  logic [DevW-1:0]   e_dev;
  logic [BlkW-1:0]   e_blk;
  logic [CntW-1:0]   e_cnt, e_cnt_dec;
  logic [IdxW-1:0]   e_rank;
  logic              scan_last;
  srch_ctrl_t        srch;
  logic              hit_f, free_f;
  logic [IdxW-1:0]   hit_idx, hit_rank, free_idx, free_rank;
  logic [CntW-1:0]   hit_cnt;

  assign s_dev    = s_axis_tdata[7:0];
  assign s_blk    = s_axis_tdata[39:8];
  assign s_idx    = s_axis_tdata[44:40];
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign idx_addr = IdxW'(idx_q);

  // unwritten slots read as their reset contents
  assign ent = written_q[rd_idx_q] ? ram_rdata
             : {1'b0, {DevW{1'b0}}, {BlkW{1'b0}}, {CntW{1'b0}}, LastIdx - rd_idx_q};
  assign e_rank    = ent[IdxW-1:0];
  assign e_cnt     = ent[IdxW +: CntW];
  assign e_blk     = ent[IdxW+CntW +: BlkW];
  assign e_dev     = ent[IdxW+CntW+BlkW +: DevW];
  assign e_asg     = ent[EntW-1];
  assign e_cnt_dec = e_cnt - CntW'(1);
  assign scan_last = rd_vld_q && (rd_idx_q == LastIdx);

  lbc_ram #(
    .WIDTH (EntW),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lbc_search #(
    .IDX_W (IdxW)
  ) u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (srch),
    .idx_i       (rd_idx_q),
    .asg_i       (e_asg),
    .dev_i       (e_dev),
    .blk_i       (e_blk),
    .cnt_i       (e_cnt),
    .rank_i      (e_rank),
    .req_dev_i   (dev_q),
    .req_blk_i   (blk_q),
    .hit_o       (hit_f),
    .hit_idx_o   (hit_idx),
    .hit_cnt_o   (hit_cnt),
    .hit_rank_o  (hit_rank),
    .free_o      (free_f),
    .free_idx_o  (free_idx),
    .free_rank_o (free_rank)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_vld_q  <= 1'b0;
      rd_cnt_q  <= '0;
      out_vld_q <= 1'b0;
      written_q <= '0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= ram_re;
      rd_cnt_q <= rd_cnt_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (ram_we) begin
        written_q[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q  <= op_e'(s_axis_tuser);
      dev_q <= s_dev;
      blk_q <= s_blk;
      idx_q <= s_idx;
    end
    rd_idx_q     <= ram_raddr;
    mru_rank_q   <= mru_rank_d;
    res_slot_q   <= res_slot_d;
    res_hit_q    <= res_hit_d;
    res_fill_q   <= res_fill_d;
    res_status_q <= res_status_d;
    res_refs_q   <= res_refs_d;
    if (load_out) begin
      out_data_q <= {1'b0, res_refs_q, res_fill_q, res_hit_q, res_slot_q};
      out_user_q <= res_status_q;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = rd_idx_q;
    ram_wdata     = ent;
    ram_re        = 1'b0;
    ram_raddr     = rd_cnt_q[IdxW-1:0];
    rd_cnt_d      = rd_cnt_q;
    mru_rank_d    = mru_rank_q;
    srch          = '0;
    res_slot_d    = res_slot_q;
    res_hit_d     = res_hit_q;
    res_fill_d    = res_fill_q;
    res_status_d  = res_status_q;
    res_refs_d    = res_refs_q;

    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          srch.clear   = 1'b1;
          rd_cnt_d     = '0;
          res_slot_d   = s_idx;
          res_hit_d    = 1'b0;
          res_fill_d   = 1'b0;
          res_status_d = STAT_OK;
          res_refs_d   = '0;
          if (op_e'(s_axis_tuser) == OP_ACQUIRE) begin
            state_d = S_A_SCAN;
          end else if (32'(s_idx) >= NUM_SLOTS) begin
            res_status_d = STAT_ZERO;
            state_d      = S_DONE;
          end else begin
            state_d = S_R_ISSUE;
          end
        end
      end

      S_R_ISSUE: begin
        ram_re    = 1'b1;
        ram_raddr = idx_addr;
        state_d   = S_R_EVAL;
      end

      S_R_EVAL: begin
        state_d = S_DONE;
        if (e_cnt == '0) begin
          res_status_d = STAT_ZERO;
        end else if (op_q == OP_PIN) begin
          if (e_cnt == CntMax) begin
            res_status_d = STAT_OVERFLOW;
            res_refs_d   = CntMax;
          end else begin
            ram_we     = 1'b1;
            ram_wdata  = {e_asg, e_dev, e_blk, CntW'(e_cnt + CntW'(1)), e_rank};
            res_refs_d = CntW'(e_cnt + CntW'(1));
          end
        end else begin
          res_refs_d = e_cnt_dec;
          if ((op_q == OP_RELEASE) && (e_cnt_dec == '0)) begin
            mru_rank_d = e_rank;
            rd_cnt_d   = '0;
            state_d    = S_M_SCAN;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = {e_asg, e_dev, e_blk, e_cnt_dec, e_rank};
          end
        end
      end

      S_A_SCAN: begin
        if (rd_cnt_q < SlotsCnt) begin
          ram_re   = 1'b1;
          rd_cnt_d = rd_cnt_q + 1'b1;
        end
        srch.en = rd_vld_q;
        if (scan_last) begin
          state_d = S_A_DECIDE;
        end
      end

      S_A_DECIDE: begin
        state_d = S_DONE;
        if (hit_f) begin
          res_slot_d = SlotW'(hit_idx);
          res_hit_d  = 1'b1;
          if (hit_cnt == CntMax) begin
            res_status_d = STAT_OVERFLOW;
            res_refs_d   = CntMax;
          end else begin
            ram_we     = 1'b1;
            ram_waddr  = hit_idx;
            ram_wdata  = {1'b1, dev_q, blk_q, CntW'(hit_cnt + CntW'(1)), hit_rank};
            res_refs_d = CntW'(hit_cnt + CntW'(1));
          end
        end else if (free_f) begin
          ram_we     = 1'b1;
          ram_waddr  = free_idx;
          ram_wdata  = {1'b1, dev_q, blk_q, CntW'(1), free_rank};
          res_slot_d = SlotW'(free_idx);
          res_fill_d = 1'b1;
          res_refs_d = CntW'(1);
        end else begin
          res_slot_d   = '0;
          res_status_d = STAT_NO_FREE;
        end
      end

      S_M_SCAN: begin
        if (rd_cnt_q < SlotsCnt) begin
          ram_re   = 1'b1;
          rd_cnt_d = rd_cnt_q + 1'b1;
        end
        if (rd_vld_q) begin
          if (rd_idx_q == idx_addr) begin
            ram_we    = 1'b1;
            ram_wdata = {e_asg, e_dev, e_blk, {CntW{1'b0}}, {IdxW{1'b0}}};
          end else if (e_rank < mru_rank_q) begin
            ram_we    = 1'b1;
            ram_wdata = {e_asg, e_dev, e_blk, e_cnt, IdxW'(e_rank + 1'b1)};
          end
        end
        if (scan_last) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  `LBC_NEVER(a_ram_rw_clash, clk_i, rst_ni, ram_we && ram_re && (ram_waddr == ram_raddr))
  `LBC_ASSERT(a_walk_bound, clk_i, rst_ni, rd_cnt_q <= SlotsCnt)
  `LBC_ASSERT(a_out_from_done, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(state_q == S_DONE))
  `LBC_ASSERT(a_nofree_zero, clk_i, rst_ni,
              (m_axis_tvalid && (m_axis_tuser == STAT_NO_FREE)) |-> (m_axis_tdata == '0))

endmodule

`default_nettype wire

[sim/lru_block_buffer_cache_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU block buffer cache testbench
// Sends acquire, release, pin and unpin requests on the input stream and
// keeps its own copy of the slot tags, counts and recency ranks to predict
// each response. Every output transfer is checked in order. Directed cases
// come first, then random traffic, later runs with random gaps on both streams.
// ----------------------------------------------------------------------------
module lru_block_buffer_cache_test;
  import lbc_pkg::*;

  localparam int unsigned Slots       = NumSlotsDflt;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 60;

  typedef struct {
    op_e              op;
    logic [DevW-1:0]  device;
    logic [BlkW-1:0]  block;
    logic [SlotW-1:0] slot;
  } request_t;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic             hit;
    logic             fill;
    status_e          status;
    logic [CntW-1:0]  refs;
  } response_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // device[7:0], block_number[39:8], slot_index[44:40]
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  // operation[1:0]
  logic [1:0]          s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // result_slot[4:0], hit[5], needs_fill[6], references[14:7]
  logic [OutDataW-1:0] m_axis_tdata;
  // status[1:0]
  logic [1:0]          m_axis_tuser;

  // local copy of the cache state
  logic [DevW-1:0] cached_dev   [Slots];
  logic [BlkW-1:0] cached_blk   [Slots];
  logic            cached_valid [Slots];
  logic [CntW-1:0] slot_refs    [Slots];
  int unsigned     slot_rank    [Slots];

  response_t   awaited_responses [$];
  response_t   want, seen;
  int unsigned pace = 1;
  int unsigned errors, sent_count, checked_count, idle_cycles;
  int unsigned hits, fills, no_free, saturated, zero_count;

  lru_block_buffer_cache #(
    .NUM_SLOTS(Slots)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic response_t predict_response(request_t rq);
    response_t   rs;
    int          best;
    int unsigned best_rank;
    int unsigned old_rank;
    rs.slot   = rq.slot;
    rs.hit    = 1'b0;
    rs.fill   = 1'b0;
    rs.status = STAT_OK;
    rs.refs   = '0;
    best      = -1;
    best_rank = 0;
    if (rq.op == OP_ACQUIRE) begin
      // only tagged slots can match
      for (int i = 0; i < Slots; i++) begin
        if (cached_valid[i] && cached_dev[i] == rq.device && cached_blk[i] == rq.block &&
            (best < 0 || slot_rank[i] < best_rank)) begin
          best      = i;
          best_rank = slot_rank[i];
        end
      end
      if (best >= 0) begin
        rs.slot = SlotW'(best);
        rs.hit  = 1'b1;
        if (slot_refs[best] == CntMax) rs.status = STAT_OVERFLOW;
        else slot_refs[best]++;
        rs.refs = slot_refs[best];
        return rs;
      end
      // victim: least recent slot with nothing holding it
      for (int i = 0; i < Slots; i++) begin
        if (slot_refs[i] == 0 && (best < 0 || slot_rank[i] > best_rank)) begin
          best      = i;
          best_rank = slot_rank[i];
        end
      end
      if (best < 0) begin
        rs.slot   = '0;
        rs.status = STAT_NO_FREE;
        return rs;
      end
      cached_dev[best]   = rq.device;
      cached_blk[best]   = rq.block;
      cached_valid[best] = 1'b1;
      slot_refs[best]    = CntW'(1);
      rs.slot = SlotW'(best);
      rs.fill = 1'b1;
      rs.refs = CntW'(1);
      return rs;
    end
    if (slot_refs[rq.slot] == 0) begin
      rs.status = STAT_ZERO;
      return rs;
    end
    if (rq.op == OP_PIN) begin
      if (slot_refs[rq.slot] == CntMax) rs.status = STAT_OVERFLOW;
      else slot_refs[rq.slot]++;
      rs.refs = slot_refs[rq.slot];
      return rs;
    end
    slot_refs[rq.slot]--;
    // unpin to zero leaves the rank alone
    if (rq.op == OP_RELEASE && slot_refs[rq.slot] == 0) begin
      old_rank = slot_rank[rq.slot];
      for (int i = 0; i < Slots; i++)
        if (slot_rank[i] < old_rank) slot_rank[i]++;
      slot_rank[rq.slot] = 0;
    end
    rs.refs = slot_refs[rq.slot];
    return rs;
  endfunction

  function automatic int unsigned pause_length(int unsigned level);
    int unsigned roll;
    roll = $urandom_range(99);
    if (level == 0 || roll < (level == 1 ? 60 : 35)) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic send_request(input request_t rq);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, rq.slot, rq.block, rq.device};
    s_axis_tuser  <= rq.op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    awaited_responses.push_back(predict_response(rq));
    sent_count++;
    gap = pause_length(pace);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic acquire_tag(input logic [DevW-1:0] dev, input logic [BlkW-1:0] blk);
    request_t rq;
    rq.op     = OP_ACQUIRE;
    rq.device = dev;
    rq.block  = blk;
    rq.slot   = SlotW'($urandom);
    send_request(rq);
  endtask

  task automatic touch_slot(input op_e op, input logic [SlotW-1:0] slot);
    request_t rq;
    rq.op     = op;
    rq.device = DevW'($urandom);
    rq.block  = $urandom;
    rq.slot   = slot;
    send_request(rq);
  endtask

  task automatic release_every_slot();
    for (int i = 0; i < Slots; i++)
      while (slot_refs[i] != 0)
        touch_slot($urandom_range(1) ? OP_RELEASE : OP_UNPIN, SlotW'(i));
  endtask

  task automatic run_directed_ops();
    // zeroed tags must not hit before they are assigned
    acquire_tag(8'h00, 32'h0000_0000);
    acquire_tag(8'h00, 32'h0000_0000);
    acquire_tag(8'hFF, 32'hFFFF_FFFF);
    acquire_tag(8'h00, 32'hFFFF_FFFF);
    acquire_tag(8'hFF, 32'h0000_0000);
    touch_slot(OP_PIN, 1);
    touch_slot(OP_UNPIN, 1);
    touch_slot(OP_UNPIN, 1);
    // count already zero
    touch_slot(OP_UNPIN, 1);
    touch_slot(OP_PIN, 1);
    touch_slot(OP_RELEASE, 1);
    touch_slot(OP_RELEASE, 31);
    touch_slot(OP_PIN, 16);
    touch_slot(OP_RELEASE, 0);
    touch_slot(OP_RELEASE, 0);
    // victim choice now depends on the rank moves above
    acquire_tag(8'h5A, 32'h1234_5678);
    acquire_tag(8'hFF, 32'hFFFF_FFFF);
    acquire_tag(8'h00, 32'h0000_0000);
    acquire_tag(8'hA5, 32'h8000_0001);
    touch_slot(OP_RELEASE, 2);
  endtask

  task automatic run_no_free_slot();
    for (int i = 0; i < Slots; i++) acquire_tag(8'hC3, i);
    acquire_tag(8'h3C, $urandom);
    acquire_tag(8'hC3, 5);
    touch_slot(OP_PIN, 9);
    acquire_tag(8'hC3, 32'hFFFF_0000);
  endtask

  task automatic run_count_saturation();
    int s;
    s = 0;
    acquire_tag(8'h77, 32'h0000_CAFE);
    for (int i = 0; i < Slots; i++)
      if (cached_valid[i] && cached_dev[i] == 8'h77 && cached_blk[i] == 32'h0000_CAFE) s = i;
    while (slot_refs[s] != CntMax) touch_slot(OP_PIN, SlotW'(s));
    touch_slot(OP_PIN, SlotW'(s));
    acquire_tag(8'h77, 32'h0000_CAFE);
    while (slot_refs[s] > 1) touch_slot(OP_UNPIN, SlotW'(s));
    touch_slot(OP_RELEASE, SlotW'(s));
  endtask

  task automatic run_random_traffic(input int unsigned count, input int unsigned level);
    int unsigned acquire_pct;
    int unsigned pick;
    int unsigned s;
    acquire_pct = 50;
    pace = level;
    for (int k = 0; k < count; k++) begin
      // switch at random between filling the cache and draining it
      if (k % 100 == 0) acquire_pct = $urandom_range(1) ? 65 : 30;
      pick = $urandom_range(99);
      if ($urandom_range(99) < acquire_pct) begin
        if (pick < 70) begin
          acquire_tag(DevW'($urandom_range(3)), $urandom_range(47));
        end else if (pick < 85) begin
          s = $urandom_range(Slots - 1);
          acquire_tag(cached_dev[s], cached_blk[s]);
        end else begin
          acquire_tag(DevW'($urandom), $urandom);
        end
      end else begin
        s = $urandom_range(Slots - 1);
        if ($urandom_range(99) < 80)
          for (int t = 0; t < Slots && slot_refs[s] == 0; t++) s = (s + 1) % Slots;
        touch_slot(pick < 50 ? OP_RELEASE : (pick < 75 ? OP_PIN : OP_UNPIN), SlotW'(s));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < Slots; i++) begin
      cached_dev[i]   = '0;
      cached_blk[i]   = '0;
      cached_valid[i] = 1'b0;
      slot_refs[i]    = '0;
      slot_rank[i]    = Slots - 1 - i;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed_ops();
    release_every_slot();
    run_no_free_slot();
    release_every_slot();
    run_count_saturation();
    run_random_traffic(400, 0);
    run_random_traffic(400, 1);
    run_random_traffic(300, 2);

    s_axis_tvalid <= 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d requests, checked %0d responses, %0d mismatches.",
             sent_count, checked_count, errors);
    $display("Seen: %0d hits, %0d fills, %0d no-free, %0d saturated, %0d zero-count.",
             hits, fills, no_free, saturated, zero_count);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // output stall generator
  initial begin : sink_pacing
    int unsigned hold;
    int unsigned len;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        len = pause_length(pace);
        if (len > 0) begin
          hold = len - 1;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      seen.slot   = m_axis_tdata[4:0];
      seen.hit    = m_axis_tdata[5];
      seen.fill   = m_axis_tdata[6];
      seen.refs   = m_axis_tdata[14:7];
      seen.status = status_e'(m_axis_tuser);
      if (awaited_responses.size() == 0) begin
        $display("%0t: unexpected transfer slot=%0d hit=%b fill=%b status=%0d refs=%0d",
                 $time, seen.slot, seen.hit, seen.fill, seen.status, seen.refs);
        errors++;
      end else begin
        want = awaited_responses.pop_front();
        checked_count++;
        if (seen !== want) begin
          $display("%0t: mismatch exp slot=%0d hit=%b fill=%b status=%0d refs=%0d", $time,
                   want.slot, want.hit, want.fill, want.status, want.refs);
          $display("%0t:          got slot=%0d hit=%b fill=%b status=%0d refs=%0d", $time,
                   seen.slot, seen.hit, seen.fill, seen.status, seen.refs);
          errors++;
        end
        if (want.hit) hits++;
        if (want.fill) fills++;
        if (want.status == STAT_NO_FREE) no_free++;
        if (want.status == STAT_OVERFLOW) saturated++;
        if (want.status == STAT_ZERO) zero_count++;
      end
    end
  end

  // watchdog on cycles with no transfer on either stream
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
